// ===== hw/rtl/mtg_pkg.sv =====
package mtg_pkg;

   localparam int WORD_W = 32;

   typedef logic [WORD_W-1:0] word_type;

   localparam int DEFAULT_STATE_WORDS = 624;
   localparam int DEFAULT_TAP_OFFSET  = 397;

   localparam word_type MT_MATRIX       = 32'h9908_b0df;
   localparam word_type MT_UPPER        = 32'h8000_0000;
   localparam word_type MT_LOWER        = 32'h7fff_ffff;
   localparam word_type MT_TEMPER_B     = 32'h9d2c_5680;
   localparam word_type MT_TEMPER_C     = 32'hefc6_0000;
   localparam word_type MT_DEFAULT_SEED = 32'd4357;
   localparam word_type MT_SEED_MULT    = 32'd69069;

   typedef enum logic {
      FUNC_DRAW   = 1'b0,
      FUNC_RESEED = 1'b1
   } func_type;

endpackage

// ===== hw/rtl/mtg_req_if.sv =====
interface mtg_req_if import mtg_pkg::*;;
   logic     valid;
   logic     ready;
   logic     func;
   word_type seed_value;

   modport source (output valid, output func, output seed_value, input ready);
   modport sink   (input valid, input func, input seed_value, output ready);
endinterface

// ===== hw/rtl/mtg_rsp_if.sv =====
interface mtg_rsp_if import mtg_pkg::*;;
   logic     valid;
   logic     ready;
   word_type random_word;

   modport source (output valid, output random_word, input ready);
   modport sink   (input valid, input random_word, output ready);
endinterface

// ===== hw/rtl/mtg_cell.sv =====
module mtg_cell import mtg_pkg::*; (
   input  logic     clock,
   input  logic     shift_en,
   input  word_type word_in,
   output word_type word_out
);

   word_type word_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         word_ff <= word_in;
      end
   end

   assign word_out = word_ff;

endmodule

// ===== hw/rtl/mtg_chain.sv =====
module mtg_chain import mtg_pkg::*; #(
   parameter int STATE_WORDS = DEFAULT_STATE_WORDS,
   parameter int TAP_OFFSET  = DEFAULT_TAP_OFFSET
) (
   input  logic     clock,
   input  logic     shift_en,
   input  word_type tail_in,
   output word_type front_word,
   output word_type next_word,
   output word_type tap_word
);

   // cell 0 holds the oldest word; new words enter at the tail
   word_type cell_q [STATE_WORDS];

   for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
      word_type cell_d;
      if (i == STATE_WORDS - 1) begin : g_tail
         assign cell_d = tail_in;
      end else begin : g_body
         assign cell_d = cell_q[i+1];
      end
      mtg_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .word_in  (cell_d),
         .word_out (cell_q[i])
      );
   end

   assign front_word = cell_q[0];
   assign next_word  = cell_q[1];
   assign tap_word   = cell_q[TAP_OFFSET];

endmodule

// ===== hw/rtl/mersenne_twister_generator_core.sv =====
// Channel   Dir  Fields                   Accepted when
// req_chan  in   func, seed_value         valid && ready
// rsp_chan  out  random_word              valid && ready
//
// A seeded draw's word is registered in the cycle after it is taken; seeded draws run
// back to back, one word per cycle unless rsp_chan stalls, as the ring of cells twists
// the word at its head while it rotates. A reseed fills the ring one word per cycle
// through the seed multiplier. The first draw after reset seeds with 4357 first.
// Reset is synchronous and clears control only; the ring holds no value until seeded.
// req_chan is held off while the ring fills and while a result waits on a stalled rsp_chan.
module mersenne_twister_generator_core import mtg_pkg::*; #(
   parameter int STATE_WORDS = DEFAULT_STATE_WORDS,
   parameter int TAP_OFFSET  = DEFAULT_TAP_OFFSET
) (
   input logic     clock,
   input logic     reset,
   mtg_req_if.sink   req_chan,
   mtg_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(STATE_WORDS);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FILL,
      ST_DRAW
   } state_type;

   function automatic word_type twist_word(word_type front, word_type nxt, word_type tap);
      word_type y;
      word_type v;
      y = (front & MT_UPPER) | (nxt & MT_LOWER);
      v = tap ^ (y >> 1);
      if (y[0]) begin
         v = v ^ MT_MATRIX;
      end
      return v;
   endfunction

   function automatic word_type temper(word_type w);
      word_type y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & MT_TEMPER_B);
      y = y ^ ((y << 15) & MT_TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   state_type        state_ff, state_in;
   logic             seeded_ff, seeded_in;
   logic             pending_ff, pending_in;
   logic [CNT_W-1:0] fill_count_ff, fill_count_in;
   word_type         fill_value_ff, fill_value_in;
   logic             rsp_valid_ff, rsp_valid_in;
   word_type         rsp_word_ff, rsp_word_in;

   word_type front_word, next_word, tap_word, twisted;
   logic     out_free, req_take, draw_now, shift_en;
   word_type tail_in;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_RUN) && out_free;
   assign req_take = req_chan.valid && req_chan.ready;

   assign twisted  = twist_word(front_word, next_word, tap_word);
   assign draw_now = (req_take && (req_chan.func == FUNC_DRAW) && seeded_ff)
                     || ((state_ff == ST_DRAW) && out_free);
   assign shift_en = draw_now || (state_ff == ST_FILL);
   assign tail_in  = (state_ff == ST_FILL) ? fill_value_ff : twisted;

   mtg_chain #(
      .STATE_WORDS (STATE_WORDS),
      .TAP_OFFSET  (TAP_OFFSET)
   ) u_chain (
      .clock      (clock),
      .shift_en   (shift_en),
      .tail_in    (tail_in),
      .front_word (front_word),
      .next_word  (next_word),
      .tap_word   (tap_word)
   );

   always_comb begin
      state_in      = state_ff;
      seeded_in     = seeded_ff;
      pending_in    = pending_ff;
      fill_count_in = fill_count_ff;
      fill_value_in = fill_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in   = rsp_word_ff;

      if (draw_now) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = temper(twisted);
      end

      case (state_ff)
         ST_RUN: begin
            if (req_take) begin
               if (req_chan.func == FUNC_RESEED) begin
                  fill_value_in = req_chan.seed_value;
                  fill_count_in = '0;
                  pending_in    = 1'b0;
                  state_in      = ST_FILL;
               end else if (!seeded_ff) begin
                  fill_value_in = MT_DEFAULT_SEED;
                  fill_count_in = '0;
                  pending_in    = 1'b1;
                  state_in      = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            fill_value_in = word_type'(fill_value_ff * MT_SEED_MULT);
            fill_count_in = fill_count_ff + CNT_W'(1);
            if (fill_count_ff == CNT_W'(STATE_WORDS - 1)) begin
               seeded_in = 1'b1;
               state_in  = pending_ff ? ST_DRAW : ST_RUN;
            end
         end
         ST_DRAW: begin
            if (out_free) begin
               pending_in = 1'b0;
               state_in   = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         seeded_ff     <= 1'b0;
         pending_ff    <= 1'b0;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seeded_ff     <= seeded_in;
         pending_ff    <= pending_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      fill_value_ff <= fill_value_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.random_word = rsp_word_ff;

   // no word may come out before the ring was ever seeded
   a_no_word_unseeded: assert property (@(posedge clock) disable iff (reset)
      !seeded_ff |-> !rsp_valid_ff)
      else $error("result word before the ring was seeded");

   // the ring must not rotate for a draw while it is being filled
   a_fill_exclusive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (!draw_now && !req_chan.ready))
      else $error("draw or accept during ring fill");

   a_fill_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (fill_count_ff <= CNT_W'(STATE_WORDS - 1)))
      else $error("fill counter past the ring length");

   // a fill ends with the ring seeded, and a deferred draw then comes out
   a_fill_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FILL) && (fill_count_ff == CNT_W'(STATE_WORDS - 1)) && pending_ff)
      |=> (seeded_ff && (state_ff == ST_DRAW) && !rsp_valid_ff))
      else $error("deferred draw lost at end of fill");

endmodule

// ===== bench/mtg_word_checker.sv =====
`timescale 1ns / 100ps

module mtg_word_checker import mtg_pkg::*; (
   input  logic clock,
   input  logic reset,
   mtg_req_if   req_mon,
   mtg_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_words
);

   localparam int RING_WORDS = DEFAULT_STATE_WORDS;
   localparam int RING_TAP   = DEFAULT_TAP_OFFSET;

   word_type   ring [RING_WORDS];
   logic [9:0] read_pos;
   word_type   expected_words [$];

   initial begin
      fail_count    = 0;
      pending_words = 0;
      read_pos      = 10'(RING_WORDS + 1);
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic void fill_ring(input word_type seed);
      ring[0] = seed;
      for (int k = 1; k < RING_WORDS; k++) begin
         ring[k] = ring[k-1] * MT_SEED_MULT;
      end
      // seeded but used up: the next draw twists first
      read_pos = 10'(RING_WORDS);
   endfunction

   function automatic void twist_ring();
      word_type nxt;
      word_type tap;
      word_type y;
      word_type v;
      for (int k = 0; k < RING_WORDS; k++) begin
         nxt = ring[(k + 1) % RING_WORDS];
         tap = ring[(k + RING_TAP) % RING_WORDS];
         y   = (ring[k] & MT_UPPER) | (nxt & MT_LOWER);
         v   = tap ^ (y >> 1);
         if (y[0]) begin
            v = v ^ MT_MATRIX;
         end
         ring[k] = v;
      end
      read_pos = '0;
   endfunction

   function automatic word_type temper(input word_type w);
      word_type y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & MT_TEMPER_B);
      y = y ^ ((y << 15) & MT_TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic word_type next_tempered_word();
      word_type w;
      if (read_pos >= 10'(RING_WORDS)) begin
         // unseeded generator seeds itself with the default first
         if (read_pos > 10'(RING_WORDS)) begin
            fill_ring(MT_DEFAULT_SEED);
         end
         twist_ring();
      end
      w = temper(ring[read_pos]);
      read_pos++;
      return w;
   endfunction

   always @(posedge clock) begin
      word_type want;
      if (reset) begin
         read_pos = 10'(RING_WORDS + 1);
         expected_words.delete();
      end else begin
         // result side first: a draw taken at this edge cannot answer at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h", rsp_mon.random_word));
            end else begin
               want = expected_words.pop_front();
               if (rsp_mon.random_word !== want) begin
                  report_mismatch($sformatf("random_word %h, expected %h",
                                            rsp_mon.random_word, want));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == FUNC_RESEED) begin
               fill_ring(req_mon.seed_value);
            end else begin
               expected_words.push_back(next_tempered_word());
            end
         end
      end
      pending_words = expected_words.size();
   end

endmodule

// ===== bench/tb_mersenne_twister_generator_core.sv =====
`timescale 1ns / 100ps

module tb_mersenne_twister_generator_core;
   import mtg_pkg::*;

   localparam int HALF_PERIOD = 10;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 700;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic steady = 1'b1;
   logic hold_armed = 1'b0;
   int   fail_count;
   int   pending_words;

   mtg_req_if req_if ();
   mtg_rsp_if rsp_if ();

   mersenne_twister_generator_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   mtg_word_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   always #HALF_PERIOD clock = ~clock;

   // worst case is far below this limit
   initial begin
      #(64'd40_000_000);
      $display("FAIL mersenne_twister_generator_core");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off once armed
   initial begin : rsp_side
      int hold_left;
      bit hold_served;
      hold_left   = 0;
      hold_served = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (hold_armed && !hold_served) begin
            hold_served = 1'b1;
            hold_left   = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= steady || ($urandom_range(99) >= 20);
         end
      end
   end

   task automatic send_word(input func_type f, input word_type seed);
      if (!steady && $urandom_range(99) < 20) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.func       <= f;
      req_if.seed_value <= seed;
      do @(posedge clock); while (!req_if.ready);
   endtask

   initial begin : stimulus
      word_type seed_pick;
      req_if.valid      = 1'b0;
      req_if.func       = FUNC_DRAW;
      req_if.seed_value = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: unseeded draw, seed extremes, back-to-back reseeds
      send_word(FUNC_DRAW, 32'hffff_ffff);
      send_word(FUNC_DRAW, 32'h0000_0000);
      send_word(FUNC_RESEED, 32'h0000_0000);
      send_word(FUNC_DRAW, 32'h0000_0000);
      send_word(FUNC_DRAW, 32'hffff_ffff);
      send_word(FUNC_RESEED, 32'hffff_ffff);
      send_word(FUNC_DRAW, 32'h5555_5555);
      send_word(FUNC_RESEED, 32'h0000_0001);
      send_word(FUNC_DRAW, 32'haaaa_aaaa);
      send_word(FUNC_RESEED, 32'h8000_0000);
      send_word(FUNC_DRAW, $urandom);
      send_word(FUNC_RESEED, 32'h7fff_ffff);
      send_word(FUNC_DRAW, $urandom);
      send_word(FUNC_RESEED, MT_DEFAULT_SEED);
      send_word(FUNC_DRAW, $urandom);
      send_word(FUNC_RESEED, $urandom);
      send_word(FUNC_RESEED, 32'h1234_5678);
      send_word(FUNC_DRAW, $urandom);
      send_word(FUNC_DRAW, $urandom);

      // long run of draws from one seed: steady first, then gaps and one long hold-off
      send_word(FUNC_RESEED, $urandom);
      for (int k = 0; k < 260; k++) begin
         if (k == 100) begin
            steady <= 1'b0;
         end
         if (k == 160) begin
            hold_armed <= 1'b1;
         end
         send_word(FUNC_DRAW, $urandom);
      end

      // mixed draws and reseeds
      for (int k = 0; k < 120; k++) begin
         if ($urandom_range(99) < 12) begin
            case ($urandom_range(7))
               0:       seed_pick = '0;
               1:       seed_pick = '1;
               2:       seed_pick = word_type'(1) << $urandom_range(31);
               default: seed_pick = $urandom;
            endcase
            send_word(FUNC_RESEED, seed_pick);
         end else begin
            send_word(FUNC_DRAW, $urandom);
         end
      end
      req_if.valid <= 1'b0;

      while (pending_words != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS mersenne_twister_generator_core");
      end else begin
         $display("FAIL mersenne_twister_generator_core");
      end
      $finish;
   end

endmodule
